FILE: rtl/ncq_pkg.sv
`default_nettype none

package ncq_pkg;

  // Default sizes
  localparam int unsigned MAX_ENTRIES_DEF  = 64;
  localparam int unsigned CHANNEL_BITS_DEF = 8;

  // Fixed field widths of the ports
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned INDEX_W    = 6;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned DIST_OUT_W = 10;
  localparam int unsigned DIST_MAX   = 1023;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CODEWORD_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE     = 2'd1;

  // Request command
  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_e;

  // Request moving down the chain
  typedef struct packed {
    logic               valid;
    cmd_e               cmd;
    logic [INDEX_W-1:0] entry_index;
    logic [PIX_W-1:0]   luma;
    logic [PIX_W-1:0]   chroma_blue;
    logic [PIX_W-1:0]   chroma_red;
  } token_t;

  // Best match found so far (index and colour as they leave the block)
  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [PIX_W-1:0]   luma;
    logic [PIX_W-1:0]   cb;
    logic [PIX_W-1:0]   cr;
  } best_t;

endpackage

`default_nettype wire

FILE: rtl/ncq_cell.sv
`default_nettype none

module ncq_cell
  import ncq_pkg::*;
#(
  parameter int unsigned INDEX        = 0,
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic [COUNT_W-1:0]      count_i,
  input  logic                    color_i,
  input  token_t                  tok_i,
  input  logic [CHANNEL_BITS+1:0] dist_i,
  input  best_t                   best_i,
  output token_t                  tok_o,
  output logic [CHANNEL_BITS+1:0] dist_o,
  output best_t                   best_o
);

  localparam int unsigned CW = CHANNEL_BITS;
  localparam int unsigned DW = CHANNEL_BITS + 2;

  logic [CW-1:0] y_q, cb_q, cr_q;
  logic [CW-1:0] px_y, px_cb, px_cr;
  logic [CW-1:0] ad_y, ad_cb, ad_cr;
  logic [DW-1:0] cand_dist;
  logic          active, take, load_hit;

  token_t        tok_q;
  logic [DW-1:0] dist_q;
  best_t         best_q;

  // Distance from the passing pixel to the held codeword
  assign px_y  = CW'(tok_i.luma);
  assign px_cb = CW'(tok_i.chroma_blue);
  assign px_cr = CW'(tok_i.chroma_red);
  assign ad_y  = (px_y  > y_q)  ? px_y  - y_q  : y_q  - px_y;
  assign ad_cb = (px_cb > cb_q) ? px_cb - cb_q : cb_q - px_cb;
  assign ad_cr = (px_cr > cr_q) ? px_cr - cr_q : cr_q - px_cr;

  always_comb begin
    cand_dist = DW'(ad_y);
    if (color_i) begin
      cand_dist = DW'(ad_y) + DW'(ad_cb) + DW'(ad_cr);
    end
  end

  // Entry 0 always seeds the search; later entries win only when strictly closer
  assign active   = (INDEX == 0) || (INDEX < 32'(count_i));
  assign take     = (INDEX == 0) || (active && (cand_dist < dist_i));
  assign load_hit = en_i && tok_i.valid && (tok_i.cmd == CMD_LOAD) &&
                    (32'(tok_i.entry_index) == INDEX);

  // Hold the codeword of this slot
  always_ff @(posedge clk_i) begin
    if (load_hit) begin
      y_q  <= px_y;
      cb_q <= px_cb;
      cr_q <= px_cr;
    end
  end

  // Advance the request and the running best match
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= '0;
      dist_q <= '0;
      best_q <= '0;
    end else if (en_i) begin
      tok_q <= tok_i;
      if (take) begin
        dist_q      <= cand_dist;
        best_q.index <= INDEX_W'(INDEX);
        best_q.luma  <= y_q[PIX_W-1:0];
        best_q.cb    <= cb_q[PIX_W-1:0];
        best_q.cr    <= cr_q[PIX_W-1:0];
      end else begin
        dist_q <= dist_i;
        best_q <= best_i;
      end
    end
  end

  assign tok_o  = tok_q;
  assign dist_o = dist_q;
  assign best_o = best_q;

endmodule

`default_nettype wire

FILE: rtl/nearest_codeword_color_quantizer.sv
`default_nettype none

// Nearest-codeword colour quantizer (L1 metric) built as a chain of cells.
// Input channel (in_valid_i/in_ready_o) takes load and pixel requests. A
// load writes one codeword (Y, Cb, Cr) into slot entry_index and gives no
// result. A pixel gives one result on the output channel (out_valid_o /
// out_ready_i): index and colour of the closest codeword among slots
// 0 to codeword_count-1, lowest index on ties, plus its distance.
// Each slot lives in its own cell; a request walks one cell per cycle while
// the chain advances, so loads and pixels stay in order. A request passes
// through the cell registers and then the output register on its way to
// out_valid_o, the first cell loaded at the accepting edge itself.
// One request per cycle is accepted while the output flows.
// When the receiver stalls with a result waiting, the whole chain holds
// and in_ready_o drops until the result is taken.
// Reset empties the chain and output register and sets codeword_count to
// 1 and color_mode to colour; codeword contents stay undefined until
// loaded. Configuration (cfg_we_i, index 0 count, index 1 mode) must be
// written by the user only while no request is in flight; the block does not enforce it.

module nearest_codeword_color_quantizer
  import ncq_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES  = MAX_ENTRIES_DEF,
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [COUNT_W-1:0]    cfg_data_i,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  command_i,
  input  logic [INDEX_W-1:0]    entry_index_i,
  input  logic [PIX_W-1:0]      luma_i,
  input  logic [PIX_W-1:0]      chroma_blue_i,
  input  logic [PIX_W-1:0]      chroma_red_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [INDEX_W-1:0]    nearest_index_o,
  output logic [PIX_W-1:0]      quant_luma_o,
  output logic [PIX_W-1:0]      quant_cb_o,
  output logic [PIX_W-1:0]      quant_cr_o,
  output logic [DIST_OUT_W-1:0] best_distance_o
);

  localparam int unsigned DW = CHANNEL_BITS + 2;

  logic [COUNT_W-1:0] count_q;
  logic               color_q;
  logic               en;

  token_t        tok      [MAX_ENTRIES+1];
  logic [DW-1:0] run_dist [MAX_ENTRIES+1];
  best_t         best     [MAX_ENTRIES+1];

  logic                  out_valid_q;
  best_t                 out_best_q;
  logic [DIST_OUT_W-1:0] out_dist_q;
  logic [DIST_OUT_W-1:0] dist_sat;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_W'(1);
      color_q <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_CODEWORD_COUNT) begin
        count_q <= cfg_data_i;
      end else if (cfg_index_i == REG_COLOR_MODE) begin
        color_q <= cfg_data_i[0];
      end
    end
  end

  // Advance the chain whenever the output register can take a new value
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Chain head: the incoming request
  assign tok[0] = '{valid: in_valid_i, cmd: cmd_e'(command_i),
                    entry_index: entry_index_i, luma: luma_i,
                    chroma_blue: chroma_blue_i, chroma_red: chroma_red_i};
  assign run_dist[0] = '0;
  assign best[0]     = '0;

  // One cell per codebook slot
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    ncq_cell #(
      .INDEX        (g),
      .CHANNEL_BITS (CHANNEL_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .count_i (count_q),
      .color_i (color_q),
      .tok_i   (tok[g]),
      .dist_i  (run_dist[g]),
      .best_i  (best[g]),
      .tok_o   (tok[g+1]),
      .dist_o  (run_dist[g+1]),
      .best_o  (best[g+1])
    );
  end

  // Saturate the winning distance to the output width
  assign dist_sat = (32'(run_dist[MAX_ENTRIES]) > DIST_MAX) ? DIST_OUT_W'(DIST_MAX)
                                                            : DIST_OUT_W'(run_dist[MAX_ENTRIES]);

  // Output register: keep pixel results, drop loads at the chain end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= tok[MAX_ENTRIES].valid && (tok[MAX_ENTRIES].cmd == CMD_PIXEL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_best_q <= best[MAX_ENTRIES];
      out_dist_q <= dist_sat;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign nearest_index_o = out_best_q.index;
  assign quant_luma_o    = out_best_q.luma;
  assign quant_cb_o      = color_q ? out_best_q.cb : '0;
  assign quant_cr_o      = color_q ? out_best_q.cr : '0;
  assign best_distance_o = out_dist_q;

  // Grey mode never shows chroma
  a_grey_chroma_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !color_q |-> (quant_cb_o == '0) && (quant_cr_o == '0))
    else $error("chroma output nonzero in grey mode");

  // The winner lies inside the searched range
  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (MAX_ENTRIES <= 64) |->
      (nearest_index_o == '0) || (COUNT_W'(nearest_index_o) < count_q))
    else $error("nearest index outside searched entries");

  // A waiting result holds the chain
  a_stall_holds_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(best_distance_o) &&
      $stable(nearest_index_o))
    else $error("chain advanced while result stalled");

endmodule

`default_nettype wire
